>>> hw/rtl/esp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package esp_pkg;

    localparam int GAIN_FRAC_BITS = 12;

    // deltas above this count as a glitch and read as zero speed
    localparam int OVER_LIMIT = 600;

    // floor(d * 81 / 5) == (d * 81 * 52429) >> 18 for every d * 81 below 2^18
    localparam logic [22:0] SPEED_MUL = 23'd4246749;
    localparam int SPEED_SHIFT = 18;

    localparam logic [2:0] CFG_TARGET_SPEED = 3'd0;
    localparam logic [2:0] CFG_P_GAIN       = 3'd1;
    localparam logic [2:0] CFG_I_GAIN       = 3'd2;
    localparam logic [2:0] CFG_D_GAIN       = 3'd3;
    localparam logic [2:0] CFG_DRIVE_MIN    = 3'd4;
    localparam logic [2:0] CFG_DRIVE_MAX    = 3'd5;

    typedef struct packed {
        logic [9:0]         target_speed;
        logic [15:0]        p_gain;
        logic [15:0]        i_gain;
        logic [15:0]        d_gain;
        logic signed [15:0] drive_min;
        logic signed [15:0] drive_max;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] error_sum;
        logic signed [15:0] last_error;
    } t_pid_state;

    typedef struct packed {
        logic signed [31:0] error_sum;
        logic signed [15:0] drive;
    } t_pid_res;

    function automatic logic [13:0] speed_of(input logic [9:0] delta);
        logic [32:0] prod;
        prod = 33'(delta) * 33'(SPEED_MUL);
        return prod[SPEED_SHIFT +: 14];
    endfunction

    function automatic t_pid_res pid_step(
        input logic signed [15:0] err,
        input t_pid_state         st,
        input t_cfg               cfg
    );
        t_pid_res           res;
        logic signed [32:0] sum_wide;
        logic signed [31:0] sum_sat;
        logic signed [16:0] pg;
        logic signed [16:0] ig;
        logic signed [16:0] dg;
        logic signed [16:0] err_diff;
        logic signed [33:0] p_term;
        logic signed [49:0] i_term;
        logic signed [33:0] d_term;
        logic signed [51:0] acc;
        logic signed [51:0] acc_sh;
        logic signed [51:0] clamped;
        sum_wide = 33'(st.error_sum) + 33'(err);
        if (sum_wide[32] != sum_wide[31]) begin
            sum_sat = sum_wide[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            sum_sat = sum_wide[31:0];
        end
        pg       = $signed({1'b0, cfg.p_gain});
        ig       = $signed({1'b0, cfg.i_gain});
        dg       = $signed({1'b0, cfg.d_gain});
        err_diff = 17'(err) - 17'(st.last_error);
        p_term   = pg * err;
        i_term   = ig * sum_sat;
        d_term   = dg * err_diff;
        acc      = 52'(p_term) + 52'(i_term) + 52'(d_term);
        acc_sh   = acc >>> GAIN_FRAC_BITS;
        // max first, then min, so min wins when the limits cross
        if (acc_sh > 52'(cfg.drive_max)) begin
            clamped = 52'(cfg.drive_max);
        end else begin
            clamped = acc_sh;
        end
        if (clamped < 52'(cfg.drive_min)) begin
            clamped = 52'(cfg.drive_min);
        end
        res.error_sum = sum_sat;
        res.drive     = clamped[15:0];
        return res;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/encoder_speed_pid_pair.sv
// a request accepted into stage one moves on to the output register once the output is free
// throughput: one request per cycle while the output is not stalled; stage one measures speed, stage two runs both pids
// the pid state is updated only as a request leaves stage two, so back-to-back requests chain
// reset (synchronous, active low) clears pipeline valids, pid state, counts and tick count,
// and loads the default configuration
`timescale 1ns / 1ps
`default_nettype none

module encoder_speed_pid_pair #(
    parameter int COUNTER_BITS = 16
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    output logic                    o_ready,
    input  wire [COUNTER_BITS-1:0]  i_left_count,
    input  wire [COUNTER_BITS-1:0]  i_right_count,
    input  wire                     i_run_enable,
    output logic                    o_valid,
    input  wire                     i_ready,
    output logic [13:0]             o_left_speed,
    output logic [13:0]             o_right_speed,
    output logic signed [15:0]      o_left_drive,
    output logic signed [15:0]      o_right_drive,
    output logic [31:0]             o_run_ticks,
    input  wire                     i_cfg_we,
    input  wire [2:0]               i_cfg_index,
    input  wire [15:0]              i_cfg_data
);

    esp_pkg::t_cfg r_cfg;

    logic                    r_s1_valid;
    logic                    r_s1_run;
    logic [13:0]             r_s1_lspeed;
    logic [13:0]             r_s1_rspeed;
    logic signed [15:0]      r_s1_lerr;
    logic signed [15:0]      r_s1_rerr;

    logic [COUNTER_BITS-1:0] r_l_last_count;
    logic [COUNTER_BITS-1:0] r_r_last_count;
    esp_pkg::t_pid_state     r_l_pid;
    esp_pkg::t_pid_state     r_r_pid;
    logic signed [15:0]      r_l_drive;
    logic signed [15:0]      r_r_drive;
    logic [31:0]             r_ticks;

    logic                    r_out_valid;
    logic [13:0]             r_out_lspeed;
    logic [13:0]             r_out_rspeed;

    logic                    w_out_free;
    logic                    w_s2_load;
    logic                    w_in_acc;
    logic [COUNTER_BITS-1:0] w_l_delta;
    logic [COUNTER_BITS-1:0] w_r_delta;
    logic [32:0]             w_l_delta_x;
    logic [32:0]             w_r_delta_x;
    logic [13:0]             w_l_speed;
    logic [13:0]             w_r_speed;
    esp_pkg::t_pid_res       w_l_res;
    esp_pkg::t_pid_res       w_r_res;

    assign w_out_free = !r_out_valid || i_ready;
    assign w_s2_load  = r_s1_valid && w_out_free;
    assign o_ready    = !r_s1_valid || w_out_free;
    assign w_in_acc   = i_valid && o_ready;

    // stage one: wrapped delta and speed
    always_comb begin
        w_l_delta   = i_left_count - r_l_last_count;
        w_r_delta   = i_right_count - r_r_last_count;
        w_l_delta_x = {{(33 - COUNTER_BITS){1'b0}}, w_l_delta};
        w_r_delta_x = {{(33 - COUNTER_BITS){1'b0}}, w_r_delta};
        if (w_l_delta_x > 33'(esp_pkg::OVER_LIMIT)) begin
            w_l_speed = '0;
        end else begin
            w_l_speed = esp_pkg::speed_of(w_l_delta_x[9:0]);
        end
        if (w_r_delta_x > 33'(esp_pkg::OVER_LIMIT)) begin
            w_r_speed = '0;
        end else begin
            w_r_speed = esp_pkg::speed_of(w_r_delta_x[9:0]);
        end
    end

    // stage two: both controllers
    assign w_l_res = esp_pkg::pid_step(r_s1_lerr, r_l_pid, r_cfg);
    assign w_r_res = esp_pkg::pid_step(r_s1_rerr, r_r_pid, r_cfg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_speed <= 10'd70;
            r_cfg.p_gain       <= 16'd614;
            r_cfg.i_gain       <= 16'd410;
            r_cfg.d_gain       <= 16'd8192;
            r_cfg.drive_min    <= 16'sd0;
            r_cfg.drive_max    <= 16'sd1000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                esp_pkg::CFG_TARGET_SPEED: r_cfg.target_speed <= i_cfg_data[9:0];
                esp_pkg::CFG_P_GAIN:       r_cfg.p_gain       <= i_cfg_data;
                esp_pkg::CFG_I_GAIN:       r_cfg.i_gain       <= i_cfg_data;
                esp_pkg::CFG_D_GAIN:       r_cfg.d_gain       <= i_cfg_data;
                esp_pkg::CFG_DRIVE_MIN:    r_cfg.drive_min    <= $signed(i_cfg_data);
                esp_pkg::CFG_DRIVE_MAX:    r_cfg.drive_max    <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid     <= 1'b0;
            r_l_last_count <= '0;
            r_r_last_count <= '0;
        end else begin
            if (w_in_acc) begin
                r_s1_valid     <= 1'b1;
                r_l_last_count <= i_left_count;
                r_r_last_count <= i_right_count;
            end else if (w_s2_load) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_run    <= i_run_enable;
            r_s1_lspeed <= w_l_speed;
            r_s1_rspeed <= w_r_speed;
            r_s1_lerr   <= $signed({6'd0, r_cfg.target_speed}) - $signed({2'd0, w_l_speed});
            r_s1_rerr   <= $signed({6'd0, r_cfg.target_speed}) - $signed({2'd0, w_r_speed});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_l_pid     <= '0;
            r_r_pid     <= '0;
            r_l_drive   <= '0;
            r_r_drive   <= '0;
            r_ticks     <= '0;
        end else begin
            if (w_s2_load) begin
                r_out_valid <= 1'b1;
                if (r_s1_run) begin
                    r_ticks              <= r_ticks + 32'd1;
                    r_l_pid.error_sum    <= w_l_res.error_sum;
                    r_l_pid.last_error   <= r_s1_lerr;
                    r_l_drive            <= w_l_res.drive;
                    r_r_pid.error_sum    <= w_r_res.error_sum;
                    r_r_pid.last_error   <= r_s1_rerr;
                    r_r_drive            <= w_r_res.drive;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_load) begin
            r_out_lspeed <= r_s1_lspeed;
            r_out_rspeed <= r_s1_rspeed;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_left_speed  = r_out_lspeed;
    assign o_right_speed = r_out_rspeed;
    assign o_left_drive  = r_l_drive;
    assign o_right_drive = r_r_drive;
    assign o_run_ticks   = r_ticks;

    // idle requests leave the controllers untouched
    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s2_load && !r_s1_run) |=> ($stable(r_l_pid) && $stable(r_r_pid)
            && $stable(r_l_drive) && $stable(r_r_drive) && $stable(r_ticks)))
        else $error("pid state changed on an idle request");

    a_tick_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s2_load && r_s1_run) |=> (r_ticks == $past(r_ticks) + 32'd1))
        else $error("tick count did not advance on a running request");

    a_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_s2_load |=> ($stable(r_ticks) && $stable(r_l_drive) && $stable(r_r_drive)))
        else $error("result changed without a new request");

    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_lspeed <= 14'd9720 && r_out_rspeed <= 14'd9720))
        else $error("speed out of range");

endmodule

`default_nettype wire

>>> test/encoder_speed_pid_pair_tb.sv
`timescale 1ns / 1ps

module encoder_speed_pid_pair_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LEFT           = 0;
    localparam int RIGHT          = 1;
    localparam int N_DIRECTED     = 15;
    localparam int PHASE_ITEMS    = 40;
    // full-rate overspeed ticks that push the integrals steadily negative
    localparam int OVERSPEED_ITEMS = 30;
    localparam longint SUM_MAX    = 64'sd2147483647;
    localparam longint SUM_MIN    = -64'sd2147483648;

    typedef struct packed {
        logic [13:0]        left_speed;
        logic [13:0]        right_speed;
        logic signed [15:0] left_drive;
        logic signed [15:0] right_drive;
        logic [31:0]        run_ticks;
    } t_result;

    typedef struct packed {
        logic [15:0] left_count;
        logic [15:0] right_count;
        logic        run;
        logic        known;
        t_result     want;
    } t_dir_row;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_valid       = 1'b0;
    logic               o_ready;
    logic [15:0]        i_left_count  = '0;
    logic [15:0]        i_right_count = '0;
    logic               i_run_enable  = 1'b0;
    logic               o_valid;
    logic               i_ready       = 1'b0;
    logic [13:0]        o_left_speed;
    logic [13:0]        o_right_speed;
    logic signed [15:0] o_left_drive;
    logic signed [15:0] o_right_drive;
    logic [31:0]        o_run_ticks;
    logic               i_cfg_we      = 1'b0;
    logic [2:0]         i_cfg_index   = '0;
    logic [15:0]        i_cfg_data    = '0;

    encoder_speed_pid_pair u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_left_count  (i_left_count),
        .i_right_count (i_right_count),
        .i_run_enable  (i_run_enable),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_left_speed  (o_left_speed),
        .o_right_speed (o_right_speed),
        .o_left_drive  (o_left_drive),
        .o_right_drive (o_right_drive),
        .o_run_ticks   (o_run_ticks),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // controller copy: configuration
    logic [9:0]         cfg_target    = 10'd70;
    logic [15:0]        cfg_p_gain    = 16'd614;
    logic [15:0]        cfg_i_gain    = 16'd410;
    logic [15:0]        cfg_d_gain    = 16'd8192;
    logic signed [15:0] cfg_drive_min = 16'sd0;
    logic signed [15:0] cfg_drive_max = 16'sd1000;

    // controller copy: per-wheel state and tick count
    logic [15:0] last_count [2];
    longint      error_sum  [2];
    longint      last_error [2];
    longint      drive_held [2];
    logic [31:0] tick_total = '0;

    t_result pending_results [$];
    int      mismatch_count = 0;
    int      gap_pct        = 0;
    int      stall_pct      = 0;
    int      hold_cycles    = 0;
    int      idle_cycles    = 0;
    logic [15:0] left_pos   = '0;
    logic [15:0] right_pos  = '0;
    t_result got;
    t_result want;
    t_dir_row dir_rows [N_DIRECTED];

    function automatic logic [13:0] wheel_speed(input int w, input logic [15:0] cnt);
        logic [15:0] delta;
        logic [31:0] scaled;
        delta = cnt - last_count[w];
        last_count[w] = cnt;
        if (delta > 16'(esp_pkg::OVER_LIMIT)) begin
            return 14'd0;
        end
        scaled = (32'(delta) * 32'd81) / 32'd5;
        return scaled[13:0];
    endfunction

    function automatic void wheel_pid_step(input int w, input longint err);
        longint sum;
        longint acc;
        sum = error_sum[w] + err;
        if (sum > SUM_MAX) begin
            sum = SUM_MAX;
        end
        if (sum < SUM_MIN) begin
            sum = SUM_MIN;
        end
        error_sum[w] = sum;
        acc = longint'(cfg_p_gain) * err + longint'(cfg_i_gain) * sum
            + longint'(cfg_d_gain) * (err - last_error[w]);
        acc = acc >>> esp_pkg::GAIN_FRAC_BITS;
        // upper limit first so the lower one wins when they cross
        if (acc > longint'(cfg_drive_max)) begin
            acc = longint'(cfg_drive_max);
        end
        if (acc < longint'(cfg_drive_min)) begin
            acc = longint'(cfg_drive_min);
        end
        drive_held[w] = acc;
        last_error[w] = err;
    endfunction

    function automatic t_result predict_tick(input logic [15:0] l, input logic [15:0] r,
                                             input logic run);
        t_result res;
        longint  err_l;
        longint  err_r;
        res.left_speed  = wheel_speed(LEFT, l);
        res.right_speed = wheel_speed(RIGHT, r);
        err_l = longint'(cfg_target) - longint'(res.left_speed);
        err_r = longint'(cfg_target) - longint'(res.right_speed);
        if (run) begin
            tick_total = tick_total + 32'd1;
            wheel_pid_step(LEFT, err_l);
            wheel_pid_step(RIGHT, err_r);
        end
        res.left_drive  = drive_held[LEFT][15:0];
        res.right_drive = drive_held[RIGHT][15:0];
        res.run_ticks   = tick_total;
        return res;
    endfunction

    task automatic send_tick(input logic [15:0] l, input logic [15:0] r, input logic run);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_left_count  <= l;
        i_right_count <= r;
        i_run_enable  <= run;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        pending_results.push_back(predict_tick(l, r, run));
        left_pos  = l;
        right_pos = r;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        unique case (idx)
            esp_pkg::CFG_TARGET_SPEED: cfg_target    = data[9:0];
            esp_pkg::CFG_P_GAIN:       cfg_p_gain    = data;
            esp_pkg::CFG_I_GAIN:       cfg_i_gain    = data;
            esp_pkg::CFG_D_GAIN:       cfg_d_gain    = data;
            esp_pkg::CFG_DRIVE_MIN:    cfg_drive_min = data;
            esp_pkg::CFG_DRIVE_MAX:    cfg_drive_max = data;
            default: ;
        endcase
    endtask

    task automatic load_gains(input logic [9:0] target, input logic [15:0] p,
                              input logic [15:0] i, input logic [15:0] d,
                              input logic [15:0] lo, input logic [15:0] hi);
        logic [5:0] junk;
        junk = 6'($urandom_range(0, 63));
        // bits above the setpoint width are don't-care
        write_reg(esp_pkg::CFG_TARGET_SPEED, {junk, target});
        write_reg(esp_pkg::CFG_P_GAIN, p);
        write_reg(esp_pkg::CFG_I_GAIN, i);
        write_reg(esp_pkg::CFG_D_GAIN, d);
        write_reg(esp_pkg::CFG_DRIVE_MIN, lo);
        write_reg(esp_pkg::CFG_DRIVE_MAX, hi);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_random_gains();
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] t;
        a = 16'($urandom_range(0, 65535));
        b = 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 3) != 0 && $signed(a) > $signed(b)) begin
            t = a;
            a = b;
            b = t;
        end
        load_gains(10'($urandom_range(0, 1023)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), a, b);
    endtask

    function automatic logic [15:0] pick_delta();
        unique case ($urandom_range(0, 19))
            0:       return 16'd600;
            1:       return 16'd601;
            2:       return 16'($urandom_range(0, 65535));
            3:       return 16'd0;
            default: return 16'($urandom_range(0, 600));
        endcase
    endfunction

    task automatic send_random_ticks(input int n);
        for (int k = 0; k < n; k++) begin
            send_tick(left_pos + pick_delta(), right_pos + pick_delta(),
                      $urandom_range(0, 7) != 0);
        end
    endtask

    task automatic run_phase(input int n, input int gap, input int stall);
        gap_pct   = gap;
        stall_pct = stall;
        send_random_ticks(n);
        wait_drained();
    endtask

    task automatic check_field(input string name, input logic signed [63:0] exp_v,
                               input logic signed [63:0] act_v);
        if (act_v !== exp_v) begin
            mismatch_count++;
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
        end
    endtask

    // output side: random stalls, or a counted hold-off when one is requested
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_ready <= 1'b0;
                hold_cycles--;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_left_speed, o_right_speed, o_left_drive, o_right_drive, o_run_ticks};
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $error("result with no pending request");
            end else begin
                want = pending_results.pop_front();
                check_field("left_speed", want.left_speed, got.left_speed);
                check_field("right_speed", want.right_speed, got.right_speed);
                check_field("left_drive", want.left_drive, got.left_drive);
                check_field("right_drive", want.right_drive, got.right_drive);
                check_field("run_ticks", want.run_ticks, got.run_ticks);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("encoder_speed_pid_pair verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        for (int w = 0; w < 2; w++) begin
            last_count[w] = '0;
            error_sum[w]  = 0;
            last_error[w] = 0;
            drive_held[w] = 0;
        end

        // defaults: setpoint 70, drive limited to 0..1000
        dir_rows[0]  = '{16'h0000, 16'h0000, 1'b0, 1'b1,
                         '{14'd0, 14'd0, 16'sd0, 16'sd0, 32'd0}};
        // exactly at the glitch limit on the left, one over on the right
        dir_rows[1]  = '{16'h0258, 16'h0259, 1'b0, 1'b1,
                         '{14'd9720, 14'd0, 16'sd0, 16'sd0, 32'd0}};
        dir_rows[2]  = '{16'h0259, 16'h025a, 1'b1, 1'b0, '0};
        dir_rows[3]  = '{16'h0259, 16'h025a, 1'b1, 1'b0, '0};
        dir_rows[4]  = '{16'hffff, 16'hffff, 1'b1, 1'b0, '0};
        // counter wrap
        dir_rows[5]  = '{16'h0004, 16'h0000, 1'b1, 1'b0, '0};
        dir_rows[6]  = '{16'h025c, 16'h0258, 1'b1, 1'b0, '0};
        dir_rows[7]  = '{16'h04b5, 16'h04b1, 1'b1, 1'b0, '0};
        dir_rows[8]  = '{16'h5555, 16'haaaa, 1'b0, 1'b0, '0};
        dir_rows[9]  = '{16'h5681, 16'haab1, 1'b1, 1'b0, '0};
        dir_rows[10] = '{16'hffff, 16'hffff, 1'b0, 1'b0, '0};
        dir_rows[11] = '{16'h0000, 16'h0000, 1'b1, 1'b0, '0};
        dir_rows[12] = '{16'h0064, 16'h00c8, 1'b1, 1'b0, '0};
        dir_rows[13] = '{16'h00c8, 16'h0190, 1'b1, 1'b0, '0};
        dir_rows[14] = '{16'h012c, 16'h0258, 1'b1, 1'b0, '0};

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < N_DIRECTED; k++) begin
            send_tick(dir_rows[k].left_count, dir_rows[k].right_count, dir_rows[k].run);
            if (dir_rows[k].known) begin
                pending_results[pending_results.size() - 1] = dir_rows[k].want;
            end
        end
        wait_drained();

        // all limits wide open, gains at full scale
        load_gains(10'd1023, 16'hffff, 16'hffff, 16'hffff, 16'h8000, 16'h7fff);
        run_phase(PHASE_ITEMS, 0, 0);

        load_gains(10'd0, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h7fff);
        run_phase(PHASE_ITEMS, 78, 0);

        load_gains(10'd500, 16'd4096, 16'd64, 16'd2048, 16'hfc18, 16'd1000);
        gap_pct   = 0;
        stall_pct = 78;
        send_random_ticks(PHASE_ITEMS);
        // long output hold-off while requests keep coming
        hold_cycles = 80;
        send_random_ticks(25);
        wait_drained();

        // crossed limits: lower limit wins
        load_gains(10'd70, 16'd614, 16'd410, 16'd8192, 16'h7fff, 16'h8000);
        run_phase(PHASE_ITEMS, 19, 19);

        // full overspeed every tick drives the integrals hard negative
        load_gains(10'd0, 16'd614, 16'd410, 16'd8192, 16'h8000, 16'h7fff);
        gap_pct   = 0;
        stall_pct = 0;
        for (int k = 0; k < OVERSPEED_ITEMS; k++) begin
            send_tick(left_pos + 16'd600, right_pos + 16'd600, 1'b1);
        end
        wait_drained();

        load_gains(10'd1023, 16'd614, 16'd410, 16'd8192, 16'h8000, 16'h7fff);
        run_phase(PHASE_ITEMS, 19, 19);

        load_random_gains();
        run_phase(PHASE_ITEMS, 78, 0);
        load_random_gains();
        run_phase(PHASE_ITEMS, 0, 78);
        load_random_gains();
        run_phase(PHASE_ITEMS, 0, 0);

        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("encoder_speed_pid_pair verification clean");
        end else begin
            $display("encoder_speed_pid_pair verification failed");
        end
        $finish;
    end

endmodule

>>> encoder_speed_pid_pair.f
hw/rtl/esp_pkg.sv
hw/rtl/encoder_speed_pid_pair.sv
test/encoder_speed_pid_pair_tb.sv
